### sv/pcwi_pkg.sv
`timescale 1ns / 1ps
package pcwi_pkg;

   localparam int CLOUDS     = 4;
   localparam int MAX_POINTS = 65536;
   localparam int DEPTH      = CLOUDS * MAX_POINTS;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int SUM_W      = ADDR_W + 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int LEN_W      = $clog2(MAX_POINTS + 1);
   localparam int HELD_W     = $clog2(CLOUDS + 1);
   localparam int CIDX_W     = $clog2(CLOUDS);
   localparam int POSE_WORDS = 24;

   localparam logic [1:0] FUNC_POSE   = 2'd0;
   localparam logic [1:0] FUNC_APPEND = 2'd1;
   localparam logic [1:0] FUNC_READ   = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef enum logic [4:0] {
      OP_NONE, OP_LATCH, OP_POSE, OP_DROP, OP_MOVE_CLR, OP_OPEN, OP_MV_RD, OP_LOAD,
      OP_MUL1, OP_MUL2, OP_ACC, OP_FIN1, OP_DIFF, OP_FIN2, OP_WB, OP_APPEND,
      OP_RD_ISSUE, OP_RD_RSP
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DROP, ST_MV_CHK, ST_MV_RD, ST_MV_LD, ST_MUL1, ST_ACC1, ST_FIN1,
      ST_DIFF, ST_MUL2, ST_ACC2, ST_FIN2, ST_WB, ST_APPEND, ST_RD_ISSUE, ST_RD_RSP
   } state_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] row;
      logic [1:0] col;
   } cmd_type;

   typedef struct packed {
      logic starts;
      logic held_zero;
      logic held_full;
      logic move_done;
   } stat_type;

   // saturate a wide signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [39:0] hi;
      logic signed [39:0] lo;
      hi = 40'sd2147483647;
      lo = -40'sd2147483648;
      if (v > hi) return 32'sh7fffffff;
      else if (v < lo) return 32'sh80000000;
      else return v[31:0];
   endfunction

endpackage

### sv/pcwi_ctrl.sv
`timescale 1ns / 1ps
module pcwi_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          func,
   input  pcwi_pkg::stat_type  stat,
   output pcwi_pkg::cmd_type   cmd,
   output logic                busy
);

   pcwi_pkg::state_type state_ff, state_in;
   logic [1:0] row_ff, row_in, col_ff, col_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcwi_pkg::ST_IDLE;
         row_ff   <= 2'd0;
         col_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      cmd.op   = pcwi_pkg::OP_NONE;
      cmd.row  = row_ff;
      cmd.col  = col_ff;
      busy     = 1'b1;
      case (state_ff)
         pcwi_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               case (func)
                  pcwi_pkg::FUNC_POSE: cmd.op = pcwi_pkg::OP_POSE;
                  pcwi_pkg::FUNC_APPEND: begin
                     cmd.op   = pcwi_pkg::OP_LATCH;
                     state_in = pcwi_pkg::ST_DROP;
                  end
                  pcwi_pkg::FUNC_READ: begin
                     cmd.op   = pcwi_pkg::OP_LATCH;
                     state_in = pcwi_pkg::ST_RD_ISSUE;
                  end
                  default: cmd.op = pcwi_pkg::OP_NONE;
               endcase
            end
         end
         pcwi_pkg::ST_DROP: begin
            if (stat.starts || stat.held_zero) begin
               cmd.op   = stat.held_full ? pcwi_pkg::OP_DROP : pcwi_pkg::OP_MOVE_CLR;
               state_in = pcwi_pkg::ST_MV_CHK;
            end else begin
               state_in = pcwi_pkg::ST_APPEND;
            end
         end
         pcwi_pkg::ST_MV_CHK: begin
            if (stat.move_done) begin
               cmd.op   = pcwi_pkg::OP_OPEN;
               state_in = pcwi_pkg::ST_APPEND;
            end else begin
               state_in = pcwi_pkg::ST_MV_RD;
            end
         end
         pcwi_pkg::ST_MV_RD: begin
            cmd.op   = pcwi_pkg::OP_MV_RD;
            state_in = pcwi_pkg::ST_MV_LD;
         end
         pcwi_pkg::ST_MV_LD: begin
            cmd.op   = pcwi_pkg::OP_LOAD;
            row_in   = 2'd0;
            col_in   = 2'd0;
            state_in = pcwi_pkg::ST_MUL1;
         end
         pcwi_pkg::ST_MUL1: begin
            cmd.op   = pcwi_pkg::OP_MUL1;
            state_in = pcwi_pkg::ST_ACC1;
         end
         pcwi_pkg::ST_ACC1: begin
            cmd.op = pcwi_pkg::OP_ACC;
            if (col_ff == 2'd2) begin
               col_in   = 2'd0;
               state_in = pcwi_pkg::ST_FIN1;
            end else begin
               col_in   = col_ff + 2'd1;
               state_in = pcwi_pkg::ST_MUL1;
            end
         end
         pcwi_pkg::ST_FIN1: begin
            cmd.op = pcwi_pkg::OP_FIN1;
            if (row_ff == 2'd2) begin
               row_in   = 2'd0;
               state_in = pcwi_pkg::ST_DIFF;
            end else begin
               row_in   = row_ff + 2'd1;
               state_in = pcwi_pkg::ST_MUL1;
            end
         end
         pcwi_pkg::ST_DIFF: begin
            cmd.op   = pcwi_pkg::OP_DIFF;
            state_in = pcwi_pkg::ST_MUL2;
         end
         pcwi_pkg::ST_MUL2: begin
            cmd.op   = pcwi_pkg::OP_MUL2;
            state_in = pcwi_pkg::ST_ACC2;
         end
         pcwi_pkg::ST_ACC2: begin
            cmd.op = pcwi_pkg::OP_ACC;
            if (col_ff == 2'd2) begin
               col_in   = 2'd0;
               state_in = pcwi_pkg::ST_FIN2;
            end else begin
               col_in   = col_ff + 2'd1;
               state_in = pcwi_pkg::ST_MUL2;
            end
         end
         pcwi_pkg::ST_FIN2: begin
            cmd.op = pcwi_pkg::OP_FIN2;
            if (row_ff == 2'd2) begin
               row_in   = 2'd0;
               state_in = pcwi_pkg::ST_WB;
            end else begin
               row_in   = row_ff + 2'd1;
               state_in = pcwi_pkg::ST_MUL2;
            end
         end
         pcwi_pkg::ST_WB: begin
            cmd.op   = pcwi_pkg::OP_WB;
            state_in = pcwi_pkg::ST_MV_CHK;
         end
         pcwi_pkg::ST_APPEND: begin
            cmd.op   = pcwi_pkg::OP_APPEND;
            state_in = pcwi_pkg::ST_IDLE;
         end
         pcwi_pkg::ST_RD_ISSUE: begin
            cmd.op   = pcwi_pkg::OP_RD_ISSUE;
            state_in = pcwi_pkg::ST_RD_RSP;
         end
         pcwi_pkg::ST_RD_RSP: begin
            cmd.op   = pcwi_pkg::OP_RD_RSP;
            state_in = pcwi_pkg::ST_IDLE;
         end
         default: state_in = pcwi_pkg::ST_IDLE;
      endcase
   end

endmodule

### sv/pcwi_dp.sv
`timescale 1ns / 1ps
module pcwi_dp (
   input  logic                clock,
   input  logic                reset,
   input  pcwi_pkg::cmd_type   cmd,
   output pcwi_pkg::stat_type  stat,
   input  logic [4:0]          req_word_index,
   input  logic signed [31:0]  req_word_value,
   input  logic signed [31:0]  req_coord_x,
   input  logic signed [31:0]  req_coord_y,
   input  logic signed [31:0]  req_coord_z,
   input  logic [31:0]         req_extra_word,
   input  logic [31:0]         req_point_label,
   input  logic                req_starts_cloud,
   input  logic [17:0]         req_read_index,
   output logic                rsp_strobe,
   output logic signed [31:0]  rsp_out_x,
   output logic signed [31:0]  rsp_out_y,
   output logic signed [31:0]  rsp_out_z,
   output logic [31:0]         rsp_out_extra,
   output logic [31:0]         rsp_out_label,
   output logic [18:0]         rsp_stored_points,
   output logic [1:0]          rsp_status
);

   localparam int AW = pcwi_pkg::ADDR_W;
   localparam int SW = pcwi_pkg::SUM_W;
   localparam int CW = pcwi_pkg::CNT_W;
   localparam int LW = pcwi_pkg::LEN_W;
   localparam int HW = pcwi_pkg::HELD_W;
   localparam int IW = pcwi_pkg::CIDX_W;
   localparam int NC = pcwi_pkg::CLOUDS;
   localparam int DP = pcwi_pkg::DEPTH;

   // point store
   logic [31:0] mem_x     [DP];
   logic [31:0] mem_y     [DP];
   logic [31:0] mem_z     [DP];
   logic [31:0] mem_extra [DP];
   logic [31:0] mem_label [DP];
   logic [31:0] rd_x_ff, rd_y_ff, rd_z_ff, rd_extra_ff, rd_label_ff;

   // window bookkeeping
   logic [LW-1:0] len_ff [NC];
   logic [HW-1:0] held_ff;
   logic [AW-1:0] base_ff;
   logic [CW-1:0] total_ff;
   logic [CW-1:0] mv_idx_ff;
   logic [31:0]   pose_ff [pcwi_pkg::POSE_WORDS];

   // request latch
   logic signed [31:0] lx_ff, ly_ff, lz_ff;
   logic [31:0]        lextra_ff, llabel_ff;
   logic               lstarts_ff;
   logic [17:0]        lri_ff;

   // arithmetic
   logic signed [31:0] p_ff [3];
   logic signed [31:0] m_ff [3];
   logic signed [31:0] d_ff [3];
   logic signed [31:0] q_ff [3];
   logic signed [63:0] prod_ff;
   logic signed [65:0] acc_ff;

   logic [4:0]         pidx;
   logic signed [31:0] mul_a, mul_b;
   logic signed [35:0] rnd;
   logic signed [65:0] acc_rnd;
   logic [IW-1:0]      cur;
   logic [SW-1:0]      mv_sum, app_sum, rd_sum, drop_sum;
   logic [AW-1:0]      mv_addr, app_addr, rd_addr, drop_addr;
   logic [AW-1:0]      mem_raddr;
   logic               full_cloud;

   function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
      if (s >= SW'(DP)) return AW'(s - SW'(DP));
      else return AW'(s);
   endfunction

   assign mv_sum    = SW'(base_ff) + SW'(mv_idx_ff);
   assign app_sum   = SW'(base_ff) + SW'(total_ff);
   assign rd_sum    = SW'(base_ff) + SW'(lri_ff);
   assign drop_sum  = SW'(base_ff) + SW'(len_ff[0]);
   assign mv_addr   = wrap(mv_sum);
   assign app_addr  = wrap(app_sum);
   assign rd_addr   = wrap(rd_sum);
   assign drop_addr = wrap(drop_sum);
   assign mem_raddr = (cmd.op == pcwi_pkg::OP_MV_RD) ? mv_addr : rd_addr;

   assign cur        = IW'(held_ff - HW'(1));
   assign full_cloud = (len_ff[cur] >= LW'(pcwi_pkg::MAX_POINTS));

   // phase 1: row-major prev rotation; phase 2: transposed curr rotation
   always_comb begin
      if (cmd.op == pcwi_pkg::OP_MUL2) begin
         pidx  = 5'd12 + 5'(cmd.col) * 5'd3 + 5'(cmd.row);
         mul_b = d_ff[cmd.col];
      end else begin
         pidx  = 5'(cmd.row) * 5'd3 + 5'(cmd.col);
         mul_b = p_ff[cmd.col];
      end
      mul_a = pose_ff[pidx];
   end

   assign acc_rnd = acc_ff + 66'sd536870912;
   assign rnd     = acc_rnd[65:30];

   assign stat.starts    = lstarts_ff;
   assign stat.held_zero = (held_ff == HW'(0));
   assign stat.held_full = (held_ff >= HW'(NC));
   assign stat.move_done = (mv_idx_ff == total_ff);

   always_ff @(posedge clock) begin
      if (cmd.op == pcwi_pkg::OP_MV_RD || cmd.op == pcwi_pkg::OP_RD_ISSUE) begin
         rd_x_ff     <= mem_x[mem_raddr];
         rd_y_ff     <= mem_y[mem_raddr];
         rd_z_ff     <= mem_z[mem_raddr];
         rd_extra_ff <= mem_extra[mem_raddr];
         rd_label_ff <= mem_label[mem_raddr];
      end
      if (cmd.op == pcwi_pkg::OP_WB) begin
         mem_x[mv_addr] <= q_ff[0];
         mem_y[mv_addr] <= q_ff[1];
         mem_z[mv_addr] <= q_ff[2];
      end else if (cmd.op == pcwi_pkg::OP_APPEND && !full_cloud) begin
         mem_x[app_addr]     <= lx_ff;
         mem_y[app_addr]     <= ly_ff;
         mem_z[app_addr]     <= lz_ff;
         mem_extra[app_addr] <= lextra_ff;
         mem_label[app_addr] <= llabel_ff;
      end
   end

   // datapath payload, no reset
   always_ff @(posedge clock) begin
      case (cmd.op)
         pcwi_pkg::OP_LATCH: begin
            lx_ff      <= req_coord_x;
            ly_ff      <= req_coord_y;
            lz_ff      <= req_coord_z;
            lextra_ff  <= req_extra_word;
            llabel_ff  <= req_point_label;
            lstarts_ff <= req_starts_cloud;
            lri_ff     <= req_read_index;
         end
         pcwi_pkg::OP_LOAD: begin
            p_ff[0] <= rd_x_ff;
            p_ff[1] <= rd_y_ff;
            p_ff[2] <= rd_z_ff;
         end
         pcwi_pkg::OP_MUL1, pcwi_pkg::OP_MUL2: prod_ff <= mul_a * mul_b;
         pcwi_pkg::OP_ACC: begin
            if (cmd.col == 2'd0) acc_ff <= 66'(prod_ff);
            else acc_ff <= acc_ff + 66'(prod_ff);
         end
         pcwi_pkg::OP_FIN1:
            m_ff[cmd.row] <= pcwi_pkg::sat32(40'(rnd) + 40'($signed(pose_ff[9 + cmd.row])));
         pcwi_pkg::OP_DIFF: begin
            for (int k = 0; k < 3; k++)
               d_ff[k] <= pcwi_pkg::sat32(40'(m_ff[k]) - 40'($signed(pose_ff[21 + k])));
         end
         pcwi_pkg::OP_FIN2: q_ff[cmd.row] <= pcwi_pkg::sat32(40'(rnd));
         default: ;
      endcase
   end

   // bookkeeping and response
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NC; i++) len_ff[i] <= '0;
         for (int i = 0; i < pcwi_pkg::POSE_WORDS; i++) pose_ff[i] <= '0;
         held_ff    <= '0;
         base_ff    <= '0;
         total_ff   <= '0;
         mv_idx_ff  <= '0;
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= (cmd.op == pcwi_pkg::OP_APPEND) || (cmd.op == pcwi_pkg::OP_RD_RSP);
         case (cmd.op)
            pcwi_pkg::OP_POSE: begin
               if (req_word_index < 5'(pcwi_pkg::POSE_WORDS))
                  pose_ff[req_word_index] <= req_word_value;
            end
            pcwi_pkg::OP_DROP: begin
               base_ff <= drop_addr;
               for (int i = 0; i + 1 < NC; i++) len_ff[i] <= len_ff[i + 1];
               held_ff   <= HW'(NC - 1);
               total_ff  <= total_ff - CW'(len_ff[0]);
               mv_idx_ff <= '0;
            end
            pcwi_pkg::OP_MOVE_CLR: mv_idx_ff <= '0;
            pcwi_pkg::OP_WB: mv_idx_ff <= mv_idx_ff + CW'(1);
            pcwi_pkg::OP_OPEN: begin
               len_ff[IW'(held_ff)] <= '0;
               held_ff <= held_ff + HW'(1);
            end
            pcwi_pkg::OP_APPEND: begin
               if (!full_cloud) begin
                  len_ff[cur] <= len_ff[cur] + LW'(1);
                  total_ff    <= total_ff + CW'(1);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == pcwi_pkg::OP_APPEND) begin
         rsp_out_x     <= '0;
         rsp_out_y     <= '0;
         rsp_out_z     <= '0;
         rsp_out_extra <= '0;
         rsp_out_label <= '0;
         if (full_cloud) begin
            rsp_stored_points <= 19'(total_ff);
            rsp_status        <= pcwi_pkg::STAT_FULL;
         end else begin
            rsp_stored_points <= 19'(total_ff + CW'(1));
            rsp_status        <= pcwi_pkg::STAT_OK;
         end
      end else if (cmd.op == pcwi_pkg::OP_RD_RSP) begin
         rsp_stored_points <= 19'(total_ff);
         if (32'(lri_ff) < 32'(total_ff)) begin
            rsp_out_x     <= rd_x_ff;
            rsp_out_y     <= rd_y_ff;
            rsp_out_z     <= rd_z_ff;
            rsp_out_extra <= rd_extra_ff;
            rsp_out_label <= rd_label_ff;
            rsp_status    <= pcwi_pkg::STAT_OK;
         end else begin
            rsp_out_x     <= '0;
            rsp_out_y     <= '0;
            rsp_out_z     <= '0;
            rsp_out_extra <= '0;
            rsp_out_label <= '0;
            rsp_status    <= pcwi_pkg::STAT_RANGE;
         end
      end
   end

endmodule

### sv/point_cloud_window_integrator.sv
`timescale 1ns / 1ps
// channel   ports                      beat taken when
// request   start, busy, req_*         start && !busy at clock edge
// response  rsp_strobe, rsp_*          rsp_strobe high, one cycle, no stall
//
// Pose write: accepted in ST_IDLE. Read: ST_RD_ISSUE, ST_RD_RSP. Append to open cloud: ST_DROP, ST_APPEND.
// Append opening a cloud first moves every held point; each held point takes
// one store read, 18 passes through the single 32x32 multiplier, one write-back.
// Reset (synchronous) clears window bookkeeping and pose words; store is not cleared.
// Response beats cannot be held off; busy covers the whole command.
module point_cloud_window_integrator (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic [4:0]         req_word_index,
   input  logic signed [31:0] req_word_value,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   input  logic [31:0]        req_extra_word,
   input  logic [31:0]        req_point_label,
   input  logic               req_starts_cloud,
   input  logic [17:0]        req_read_index,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic [31:0]        rsp_out_extra,
   output logic [31:0]        rsp_out_label,
   output logic [18:0]        rsp_stored_points,
   output logic [1:0]         rsp_status
);

   pcwi_pkg::cmd_type  cmd;
   pcwi_pkg::stat_type stat;

   // sequencer: command decode, move loop, multiply-accumulate steps
   pcwi_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .func  (req_func),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // store, pose words, window counters, MAC and response registers
   pcwi_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_word_index    (req_word_index),
      .req_word_value    (req_word_value),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .req_coord_z       (req_coord_z),
      .req_extra_word    (req_extra_word),
      .req_point_label   (req_point_label),
      .req_starts_cloud  (req_starts_cloud),
      .req_read_index    (req_read_index),
      .rsp_strobe        (rsp_strobe),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_out_z         (rsp_out_z),
      .rsp_out_extra     (rsp_out_extra),
      .rsp_out_label     (rsp_out_label),
      .rsp_stored_points (rsp_stored_points),
      .rsp_status        (rsp_status)
   );

endmodule

### tb/tb_point_cloud_window_integrator.sv
`timescale 1ns / 1ps
module tb_point_cloud_window_integrator;
   import pcwi_pkg::*;

   // func code the block ignores
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int LIMIT_CYCLES = 3_000_000;
   localparam int TAIL_CYCLES  = 60;
   localparam int RANDOM_ITEMS = 650;

   typedef struct {
      logic [1:0]         func;
      logic [4:0]         word_index;
      logic signed [31:0] word_value;
      logic signed [31:0] x, y, z;
      logic [31:0]        extra, label;
      logic               starts;
      logic [17:0]        read_index;
      int                 gap;
   } beat_type;

   typedef struct {
      logic signed [31:0] x, y, z;
      logic [31:0]        extra, label;
      logic [18:0]        stored;
      logic [1:0]         status;
   } point_rsp_type;

   logic               clock, reset, start, busy;
   logic [1:0]         req_func;
   logic [4:0]         req_word_index;
   logic signed [31:0] req_word_value, req_coord_x, req_coord_y, req_coord_z;
   logic [31:0]        req_extra_word, req_point_label;
   logic               req_starts_cloud;
   logic [17:0]        req_read_index;
   logic               rsp_strobe;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic [31:0]        rsp_out_extra, rsp_out_label;
   logic [18:0]        rsp_stored_points;
   logic [1:0]         rsp_status;

   point_cloud_window_integrator u_top (.*);

   // ---------------------------------------------------------------------
   // Clock and reset
   // ---------------------------------------------------------------------
   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // ---------------------------------------------------------------------
   // Window predictor: own copy of pose, ring store and cloud bookkeeping
   // ---------------------------------------------------------------------
   logic signed [31:0] pose_reg [POSE_WORDS];
   logic [31:0]        win_x [int], win_y [int], win_z [int];
   logic [31:0]        win_extra [int], win_label [int];
   int                 cloud_len [CLOUDS];
   int                 held_clouds;
   int                 oldest_addr;
   point_rsp_type      rsp_expected [$];

   int  errors    = 0;
   int  cycles    = 0;
   int  issued    = 0;
   int  accepted  = 0;
   int  waited    = 0;
   beat_type pending [$];

   function automatic logic signed [31:0] clamp32(input logic signed [39:0] v);
      if (v > 40'sd2147483647) return 32'sh7fffffff;
      if (v < -40'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // exact three-term dot product, scaled by 2^-30, rounded half up
   function automatic logic signed [39:0] rot_dot(
         input logic signed [31:0] r0, r1, r2,
         input logic signed [31:0] p0, p1, p2);
      logic signed [67:0] a0, a1, a2, b0, b1, b2, acc;
      a0 = r0; a1 = r1; a2 = r2;
      b0 = p0; b1 = p1; b2 = p2;
      acc = a0 * b0 + a1 * b1 + a2 * b2 + (68'sd1 <<< 29);
      acc = acc >>> 30;
      return acc[39:0];
   endfunction

   function automatic int window_total();
      int s;
      s = 0;
      for (int i = 0; i < held_clouds; i++) s += cloud_len[i];
      return s;
   endfunction

   // prev pose forward, then inverse of current pose
   task automatic move_point(input int a);
      logic signed [31:0] p [3];
      logic signed [31:0] m [3];
      logic signed [31:0] d [3];
      logic signed [39:0] mv, tv;
      p[0] = win_x[a]; p[1] = win_y[a]; p[2] = win_z[a];
      for (int r = 0; r < 3; r++) begin
         tv = pose_reg[9 + r];
         m[r] = clamp32(rot_dot(pose_reg[3*r], pose_reg[3*r+1], pose_reg[3*r+2],
                                p[0], p[1], p[2]) + tv);
      end
      for (int k = 0; k < 3; k++) begin
         mv = m[k];
         tv = pose_reg[21 + k];
         d[k] = clamp32(mv - tv);
      end
      // transposed current rotation: column r of the matrix
      for (int r = 0; r < 3; r++)
         p[r] = clamp32(rot_dot(pose_reg[12 + r], pose_reg[15 + r], pose_reg[18 + r],
                                d[0], d[1], d[2]));
      win_x[a] = p[0]; win_y[a] = p[1]; win_z[a] = p[2];
   endtask

   task automatic predict_window(input beat_type b);
      point_rsp_type e;
      int tot, a;
      e = '{default: '0};
      case (b.func)
         FUNC_POSE: begin
            if (b.word_index < POSE_WORDS) pose_reg[b.word_index] = b.word_value;
         end
         FUNC_APPEND: begin
            e.status = STAT_OK;
            // new cloud, or first point with nothing held
            if (b.starts || held_clouds == 0) begin
               if (held_clouds >= CLOUDS) begin
                  oldest_addr = (oldest_addr + cloud_len[0]) % DEPTH;
                  for (int i = 0; i + 1 < CLOUDS; i++) cloud_len[i] = cloud_len[i + 1];
                  held_clouds = CLOUDS - 1;
               end
               tot = window_total();
               for (int i = 0; i < tot; i++) move_point((oldest_addr + i) % DEPTH);
               cloud_len[held_clouds] = 0;
               held_clouds++;
            end
            tot = window_total();
            if (cloud_len[held_clouds - 1] >= MAX_POINTS) begin
               e.status = STAT_FULL;
            end else begin
               a = (oldest_addr + tot) % DEPTH;
               win_x[a] = b.x; win_y[a] = b.y; win_z[a] = b.z;
               win_extra[a] = b.extra; win_label[a] = b.label;
               cloud_len[held_clouds - 1]++;
               tot++;
            end
            e.stored = tot;
            rsp_expected.push_back(e);
         end
         FUNC_READ: begin
            tot = window_total();
            if (b.read_index < tot) begin
               a = (oldest_addr + b.read_index) % DEPTH;
               e.x = win_x[a]; e.y = win_y[a]; e.z = win_z[a];
               e.extra = win_extra[a]; e.label = win_label[a];
               e.status = STAT_OK;
            end else begin
               e.status = STAT_RANGE;
            end
            e.stored = tot;
            rsp_expected.push_back(e);
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Driver: inputs move on the falling edge; one start assignment per step
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset && issued == accepted) begin
         if (pending.size() != 0 && waited >= pending[0].gap) begin
            beat_type b;
            b = pending.pop_front();
            req_func         <= b.func;
            req_word_index   <= b.word_index;
            req_word_value   <= b.word_value;
            req_coord_x      <= b.x;
            req_coord_y      <= b.y;
            req_coord_z      <= b.z;
            req_extra_word   <= b.extra;
            req_point_label  <= b.label;
            req_starts_cloud <= b.starts;
            req_read_index   <= b.read_index;
            start            <= 1'b1;
            issued++;
            waited = 0;
         end else begin
            start <= 1'b0;
            if (pending.size() != 0) waited++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: check the response beat first, then predict the accepted one
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_strobe) begin
         if (rsp_expected.size() == 0) begin
            $display("%0t: unexpected response beat, stored %0d status %0d",
                     $time, rsp_stored_points, rsp_status);
            errors++;
         end else begin
            point_rsp_type e;
            e = rsp_expected.pop_front();
            if (rsp_out_x !== e.x) begin
               $display("%0t: x exp %h got %h", $time, e.x, rsp_out_x); errors++;
            end
            if (rsp_out_y !== e.y) begin
               $display("%0t: y exp %h got %h", $time, e.y, rsp_out_y); errors++;
            end
            if (rsp_out_z !== e.z) begin
               $display("%0t: z exp %h got %h", $time, e.z, rsp_out_z); errors++;
            end
            if (rsp_out_extra !== e.extra) begin
               $display("%0t: extra exp %h got %h", $time, e.extra, rsp_out_extra);
               errors++;
            end
            if (rsp_out_label !== e.label) begin
               $display("%0t: label exp %h got %h", $time, e.label, rsp_out_label);
               errors++;
            end
            if (rsp_stored_points !== e.stored) begin
               $display("%0t: stored exp %0d got %0d", $time, e.stored, rsp_stored_points);
               errors++;
            end
            if (rsp_status !== e.status) begin
               $display("%0t: status exp %0d got %0d", $time, e.status, rsp_status);
               errors++;
            end
         end
      end
      if (!reset && start && !busy) begin
         beat_type b;
         b.func = req_func; b.word_index = req_word_index; b.word_value = req_word_value;
         b.x = req_coord_x; b.y = req_coord_y; b.z = req_coord_z;
         b.extra = req_extra_word; b.label = req_point_label;
         b.starts = req_starts_cloud; b.read_index = req_read_index; b.gap = 0;
         predict_window(b);
         accepted++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles > LIMIT_CYCLES) begin
         $display("** point_cloud_window_integrator: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus generation
   // ---------------------------------------------------------------------
   bit burst;   // stretch with no gaps

   function automatic int draw_gap();
      if ($urandom_range(0, 40) == 0) burst = ~burst;
      return burst ? 0 : $urandom_range(0, 13);
   endfunction

   function automatic logic signed [31:0] draw_coord();
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
      endcase
   endfunction

   task automatic push_pose(input logic [4:0] idx, input logic signed [31:0] v);
      beat_type b;
      b = '{default: '0};
      b.func = FUNC_POSE; b.word_index = idx; b.word_value = v; b.gap = draw_gap();
      b.x = $urandom(); b.read_index = $urandom();
      pending.push_back(b);
   endtask

   task automatic push_point(input bit starts, input int gap);
      beat_type b;
      b = '{default: '0};
      b.func = FUNC_APPEND; b.starts = starts; b.gap = gap;
      b.x = draw_coord(); b.y = draw_coord(); b.z = draw_coord();
      b.extra = $urandom(); b.label = $urandom();
      b.word_index = $urandom(); b.read_index = $urandom();
      pending.push_back(b);
   endtask

   task automatic push_read(input logic [17:0] ri, input int gap);
      beat_type b;
      b = '{default: '0};
      b.func = FUNC_READ; b.read_index = ri; b.gap = gap;
      pending.push_back(b);
   endtask

   // whole pose: identity, near identity, random or extreme
   task automatic push_full_pose();
      int kind;
      logic signed [31:0] v;
      kind = $urandom_range(0, 5);
      for (int w = 0; w < POSE_WORDS; w++) begin
         if (w % 12 < 9) begin
            case (kind)
               0:       v = (w % 12 % 4 == 0) ? 32'sh40000000 : 32'sh0;
               1:       v = $urandom();
               2:       v = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
               default: v = ((w % 12 % 4 == 0) ? 32'sh40000000 : 32'sh0)
                            + $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
            endcase
         end else begin
            case (kind)
               1:       v = $urandom();
               2:       v = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
               default: v = $signed($urandom_range(0, 32'h003fffff)) - 32'sh00200000;
            endcase
         end
         push_pose(w, v);
      end
   endtask

   initial begin
      beat_type b;
      int n;
      reset = 1'b1; start = 1'b0;
      req_func = '0; req_word_index = '0; req_word_value = '0;
      req_coord_x = '0; req_coord_y = '0; req_coord_z = '0;
      req_extra_word = '0; req_point_label = '0;
      req_starts_cloud = 1'b0; req_read_index = '0;
      for (int i = 0; i < POSE_WORDS; i++) pose_reg[i] = '0;
      for (int i = 0; i < CLOUDS; i++) cloud_len[i] = 0;
      held_clouds = 0; oldest_addr = 0;
      burst = 0;

      // directed part
      push_read(18'd0, 0);                 // empty window
      push_read(18'h3ffff, 2);
      b = '{default: '0}; b.func = FUNC_UNUSED; b.gap = 1; pending.push_back(b);
      push_pose(5'd24, 32'sh12345678);     // beyond the pose words
      push_pose(5'd31, 32'shffffffff);
      // first point without a cloud mark opens one
      b = '{default: '0}; b.func = FUNC_APPEND; b.starts = 1'b0;
      b.x = 32'sh7fffffff; b.y = 32'sh80000000; b.z = 32'sh7fffffff;
      b.extra = '1; b.label = '1; pending.push_back(b);
      b.x = 32'sh80000000; b.y = 32'sh7fffffff; b.z = 32'sh80000000;
      b.extra = '0; b.label = '0; b.gap = 3; pending.push_back(b);
      push_read(18'd0, 0); push_read(18'd1, 0); push_read(18'd2, 0);
      push_pose(5'd0, 32'sh40000000);  push_pose(5'd4, 32'sh40000000);
      push_pose(5'd8, 32'sh40000000);  push_pose(5'd9, 32'sh00010000);
      push_pose(5'd12, 32'sh40000000); push_pose(5'd16, 32'sh40000000);
      push_pose(5'd20, 32'sh40000000); push_pose(5'd21, 32'shffff0000);
      push_point(1'b1, 0);                 // moves saturating points
      push_read(18'd0, 0); push_read(18'd1, 4);

      // random part: clouds of a few points, reads, pose updates
      n = 0;
      while (n < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: begin
               push_full_pose(); n += POSE_WORDS;
            end
            1: begin
               b = '{default: '0};
               b.func = $urandom_range(0, 1) ? FUNC_UNUSED : FUNC_POSE;
               b.word_index = $urandom_range(24, 31); b.word_value = $urandom();
               b.gap = draw_gap(); pending.push_back(b);
            end
            2, 3, 4, 5: begin
               int len;
               len = $urandom_range(1, 6);
               for (int i = 0; i < len; i++) push_point(i == 0, draw_gap());
               n += len;
            end
            default: begin
               push_read($urandom_range(0, 9) == 0 ? 18'($urandom()) :
                         18'($urandom_range(0, 30)), draw_gap());
               n++;
            end
         endcase
      end

      for (int i = 0; i < 8; i++) push_read(18'($urandom()), draw_gap());
      push_read(18'd0, 0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (pending.size() == 0 && issued == accepted);
      wait (rsp_expected.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0 && rsp_expected.size() == 0)
         $display("** point_cloud_window_integrator: PASSED **");
      else
         $display("** point_cloud_window_integrator: FAILED **");
      $finish;
   end

endmodule

### sim.f
sv/pcwi_pkg.sv
sv/pcwi_ctrl.sv
sv/pcwi_dp.sv
sv/point_cloud_window_integrator.sv
tb/tb_point_cloud_window_integrator.sv
